>>> rtl/multi_level_timer_scheduler_macros.svh
// ---------------------------------------------------------------------------
// Timer scheduler assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MULTI_LEVEL_TIMER_SCHEDULER_MACROS_SVH
`define MULTI_LEVEL_TIMER_SCHEDULER_MACROS_SVH

// same-cycle implication
`define MLTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MLTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mlts_pkg.sv
// ---------------------------------------------------------------------------
// mlts_pkg
// Types, codes and constants of the multi-level timer scheduler.
// ---------------------------------------------------------------------------
package mlts_pkg;

  localparam int TICK_W     = 32;
  localparam int THR_W      = 24;
  localparam int PER_W      = 16;
  localparam int DELAY_W    = 24;
  localparam int PAY_W      = 64;
  localparam int SLOT_W     = 4;
  localparam int LVL_W      = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;
  localparam int NUM_CFG_LV = 4;
  localparam int MAX_RESULTS = 16;
  localparam int FCNT_W     = $clog2(MAX_RESULTS + 1);
  localparam int DIV_CNT_W  = $clog2(TICK_W);

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1_THR = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL4_THR = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1_PER = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL4_PER = 4'd7;

  typedef logic [NUM_CFG_LV-1:0][THR_W-1:0] thr_arr_t;
  typedef logic [NUM_CFG_LV-1:0][PER_W-1:0] per_arr_t;

  localparam thr_arr_t THR_RESET = {24'd1000, 24'd500, 24'd100, 24'd50};
  localparam per_arr_t PER_RESET = {16'd50, 16'd15, 16'd8, 16'd3};

  typedef enum logic [1:0] {
    RES_ADDED      = 2'd0,
    RES_ZERO_DELAY = 2'd1,
    RES_NO_SLOT    = 2'd2,
    RES_FIRED      = 2'd3
  } res_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RECALC,
    ST_ADD_SCAN,
    ST_TICK_INC,
    ST_WALK,
    ST_FLUSH
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic cfg_we;
    logic div_start;
    logic div_step;
    logic add_zero;
    logic add_write;
    logic add_full;
    logic tick_inc;
    logic walk_step;
    logic flush;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_is_tick;
    logic delay_zero;
    logic slot_free;
    logic lvl_active;
    logic fire;
    logic pend_valid;
    logic out_free;
    logic div_last;
    logic cfg_is_period;
  } dp_stat_t;

  // highest level whose threshold the remaining time meets
  function automatic logic [LVL_W-1:0] pick_level(input logic [TICK_W-1:0] rem,
                                                  input thr_arr_t thr,
                                                  input int num_levels);
    logic [LVL_W-1:0] lv;
    lv = '0;
    if (!rem[TICK_W-1]) begin
      for (int k = 1; k <= NUM_CFG_LV; k++) begin
        if (k < num_levels && rem >= {{(TICK_W-THR_W){1'b0}}, thr[k-1]}) begin
          lv = LVL_W'(k);
        end
      end
    end
    return lv;
  endfunction

endpackage

>>> rtl/mlts_ifs.sv
// ---------------------------------------------------------------------------
// Channel interfaces
// Request, result and configuration-write channels, valid/ready.
// ---------------------------------------------------------------------------
interface mlts_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [23:0] delay;
  logic [63:0] payload;
  modport source (output valid, req_type, delay, payload, input ready);
  modport sink (input valid, req_type, delay, payload, output ready);
endinterface

interface mlts_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  res_kind;
  logic [3:0]  slot;
  logic [63:0] fired_payload;
  logic        last;
  modport source (output valid, res_kind, slot, fired_payload, last, input ready);
  modport sink (input valid, res_kind, slot, fired_payload, last, output ready);
endinterface

interface mlts_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/multi_level_timer_scheduler.sv
// Add: captured in idle, scans slots from the lowest until a free one, then flushes to the result register.
// Tick: the count advances, then each level pass that runs walks every slot and a skipped level takes
//   a single walk step; one slot walked per cycle while a firing is not stalled by a full output register.
// Period write: a bit-serial remainder pass over the tick count (one bit per cycle) realigns the level phase.
// One request at a time; a finished result waits in the output register.
// Reset clears the pool valid bits, tick count, phases and registers; no sweep.
// ---------------------------------------------------------------------------
// multi_level_timer_scheduler
// Pool of one-shot timers filed into levels by remaining time. Add requests
// take the lowest free slot; tick requests advance time, re-file the levels
// whose period divides the count and fire due level-zero timers in slot order.
// ---------------------------------------------------------------------------
`include "multi_level_timer_scheduler_macros.svh"

module multi_level_timer_scheduler import mlts_pkg::*; #(
  parameter int NUM_TIMERS = 16,
  parameter int NUM_LEVELS = 5
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  mlts_req_if.sink   req_i,
  mlts_res_if.source res_o,
  mlts_cfg_if.sink   cfg_i
);

  localparam int IDX_W = $clog2(NUM_TIMERS);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [IDX_W-1:0] idx;
  logic [LVL_W-1:0] lvl;
  res_kind_e        res_kind;
  logic             res_not_fire;

  // sequencer: owns both ready lines, walks slots and levels
  mlts_ctrl #(
    .NUM_TIMERS (NUM_TIMERS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .idx_o       (idx),
    .lvl_o       (lvl)
  );

  // datapath: pool storage, timebase, pending result held until the next
  // firing or the end of the walk decides its last flag
  mlts_datapath #(
    .NUM_TIMERS (NUM_TIMERS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .idx_i         (idx),
    .lvl_i         (lvl),
    .stat_o        (stat),
    .req_type_i    (req_i.req_type),
    .delay_i       (req_i.delay),
    .payload_i     (req_i.payload),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .res_valid_o   (res_o.valid),
    .res_ready_i   (res_o.ready),
    .res_kind_o    (res_kind),
    .res_slot_o    (res_o.slot),
    .res_payload_o (res_o.fired_payload),
    .res_last_o    (res_o.last)
  );

  assign res_o.res_kind = res_kind;
  assign res_not_fire   = res_o.valid && (res_kind != RES_FIRED);

  // add and reject results are single-result requests
  `MLTS_ASSERT_NOW(a_single_last, res_not_fire, res_o.last, "non-fire result without last")
  // only fired results carry a payload
  `MLTS_ASSERT_NOW(a_zero_payload, res_not_fire, res_o.fired_payload == '0, "payload on non-fire")
  // an accepted request leaves the block busy, ready low, in the following cycle
  `MLTS_ASSERT_NEXT(a_busy_after_req, req_i.valid && req_i.ready, !req_i.ready, "taken while busy")

endmodule

>>> rtl/mlts_ctrl.sv
// ---------------------------------------------------------------------------
// mlts_ctrl
// Sequencer: request and config intake, slot scan, level passes and result flush.
// ---------------------------------------------------------------------------
module mlts_ctrl import mlts_pkg::*; #(
  parameter int NUM_TIMERS = 16,
  parameter int NUM_LEVELS = 5,
  localparam int IDX_W = $clog2(NUM_TIMERS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  dp_stat_t         stat_i,
  output dp_cmd_t          cmd_o,
  output logic [IDX_W-1:0] idx_o,
  output logic [LVL_W-1:0] lvl_o
);

  ctrl_state_e      state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic             idx_last, lvl_last, stall;

  assign idx_last = (idx_q == IDX_W'(NUM_TIMERS - 1));
  assign lvl_last = (lvl_q == LVL_W'(NUM_LEVELS - 1));
  assign stall    = stat_i.fire && stat_i.pend_valid && !stat_i.out_free;
  assign idx_o    = idx_q;
  assign lvl_o    = lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      lvl_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      lvl_q   <= lvl_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    lvl_d       = lvl_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    cfg_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cfg_ready_o = 1'b1;
        req_ready_o = !cfg_valid_i;
        idx_d       = '0;
        lvl_d       = '0;
        if (cfg_valid_i) begin
          cmd_o.cfg_we = 1'b1;
          if (stat_i.cfg_is_period) begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_RECALC;
          end
        end else if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_ADD_SCAN;
        end
      end
      ST_RECALC: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_ADD_SCAN: begin
        if (stat_i.req_is_tick) begin
          state_d = ST_TICK_INC;
        end else if (stat_i.delay_zero) begin
          cmd_o.add_zero = 1'b1;
          state_d        = ST_FLUSH;
        end else if (stat_i.slot_free) begin
          cmd_o.add_write = 1'b1;
          state_d         = ST_FLUSH;
        end else if (idx_last) begin
          cmd_o.add_full = 1'b1;
          state_d        = ST_FLUSH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_TICK_INC: begin
        cmd_o.tick_inc = 1'b1;
        idx_d          = '0;
        lvl_d          = '0;
        state_d        = ST_WALK;
      end
      ST_WALK: begin
        if (!stat_i.lvl_active || !stall) begin
          cmd_o.walk_step = stat_i.lvl_active;
          if (!stat_i.lvl_active || idx_last) begin
            idx_d = '0;
            if (lvl_last) begin
              state_d = ST_FLUSH;
            end else begin
              lvl_d = lvl_q + 1'b1;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!stat_i.pend_valid) begin
          state_d = ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/mlts_datapath.sv
// ---------------------------------------------------------------------------
// mlts_datapath
// Slot pool, tick counter, level phases, remainder unit and result regs.
// ---------------------------------------------------------------------------
module mlts_datapath import mlts_pkg::*; #(
  parameter int NUM_TIMERS = 16,
  parameter int NUM_LEVELS = 5,
  localparam int IDX_W = $clog2(NUM_TIMERS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  logic [LVL_W-1:0]      lvl_i,
  output dp_stat_t              stat_o,
  input  logic                  req_type_i,
  input  logic [DELAY_W-1:0]    delay_i,
  input  logic [PAY_W-1:0]      payload_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output res_kind_e             res_kind_o,
  output logic [SLOT_W-1:0]     res_slot_o,
  output logic [PAY_W-1:0]      res_payload_o,
  output logic                  res_last_o
);

  localparam int EXT_W = IDX_W + SLOT_W;

  // configuration and timebase
  thr_arr_t                       thr_q;
  per_arr_t                       per_q;
  logic [TICK_W-1:0]              tick_q, tick_inc;
  logic [NUM_CFG_LV-1:0][PER_W-1:0] phase_q;

  // slot pool
  logic [NUM_TIMERS-1:0]          valid_q;
  logic [TICK_W-1:0]              deadline_q [NUM_TIMERS];
  logic [PAY_W-1:0]               payload_q  [NUM_TIMERS];
  logic [LVL_W-1:0]               level_q    [NUM_TIMERS];

  // captured request
  logic                           rtype_q;
  logic [DELAY_W-1:0]             delay_q;
  logic [PAY_W-1:0]               rpay_q;

  // remainder unit
  logic [DIV_CNT_W-1:0]           div_cnt_q;
  logic [PER_W-1:0]               div_rem_q;
  logic [1:0]                     div_lv_q;
  logic [PER_W:0]                 div_trial, div_next;
  logic [CFG_IDX_W-1:0]           cfg_off;

  // pending and output result
  logic                           pend_valid_q;
  res_kind_e                      pend_kind_q;
  logic [SLOT_W-1:0]              pend_slot_q;
  logic [PAY_W-1:0]               pend_pay_q;
  logic                           out_valid_q;
  res_kind_e                      out_kind_q;
  logic [SLOT_W-1:0]              out_slot_q;
  logic [PAY_W-1:0]               out_pay_q;
  logic                           out_last_q;
  logic [FCNT_W-1:0]              fcnt_q;

  logic [TICK_W-1:0]              rem;
  logic                           match, due, lvl_active, fire, out_free;
  logic [LVL_W-1:0]               lvl_m1;
  logic [EXT_W-1:0]               idx_ext;
  logic [SLOT_W-1:0]              idx_slot;

  assign tick_inc = tick_q + 1'b1;
  assign rem      = deadline_q[idx_i] - tick_q;
  assign match    = valid_q[idx_i] && (level_q[idx_i] == lvl_i);
  assign due      = (rem == '0) || rem[TICK_W-1];
  assign lvl_m1   = lvl_i - 1'b1;
  assign lvl_active = (lvl_i == '0) ||
                      ((per_q[lvl_m1[1:0]] != '0) && (phase_q[lvl_m1[1:0]] == '0));
  assign fire     = match && (lvl_i == '0) && due && (fcnt_q < FCNT_W'(MAX_RESULTS));
  assign out_free = !out_valid_q || res_ready_i;
  assign idx_ext  = EXT_W'(idx_i);
  assign idx_slot = idx_ext[SLOT_W-1:0];
  assign cfg_off  = cfg_index_i - CFG_LEVEL1_PER;

  assign div_trial = {div_rem_q, tick_q[div_cnt_q]};
  assign div_next  = (div_trial >= {1'b0, per_q[div_lv_q]}) ?
                     (div_trial - {1'b0, per_q[div_lv_q]}) : div_trial;

  always_comb begin
    stat_o               = '0;
    stat_o.req_is_tick   = (rtype_q == REQ_TICK);
    stat_o.delay_zero    = (delay_q == '0);
    stat_o.slot_free     = !valid_q[idx_i];
    stat_o.lvl_active    = lvl_active;
    stat_o.fire          = fire;
    stat_o.pend_valid    = pend_valid_q;
    stat_o.out_free      = out_free;
    stat_o.div_last      = (div_cnt_q == '0);
    stat_o.cfg_is_period = cfg_index_i inside {[CFG_LEVEL1_PER:CFG_LEVEL4_PER]};
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= THR_RESET;
      per_q        <= PER_RESET;
      tick_q       <= '0;
      phase_q      <= '0;
      valid_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      fcnt_q       <= '0;
      div_cnt_q    <= '0;
    end else begin
      if (cmd_i.cfg_we) begin
        if (cfg_index_i inside {[CFG_LEVEL1_THR:CFG_LEVEL4_THR]}) begin
          thr_q[cfg_index_i[1:0]] <= cfg_data_i;
        end else if (cfg_index_i inside {[CFG_LEVEL1_PER:CFG_LEVEL4_PER]}) begin
          per_q[cfg_off[1:0]] <= cfg_data_i[PER_W-1:0];
        end
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= DIV_CNT_W'(TICK_W - 1);
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q - 1'b1;
        if (div_cnt_q == '0) begin
          phase_q[div_lv_q] <= (per_q[div_lv_q] == '0) ? '0 : div_next[PER_W-1:0];
        end
      end
      if (cmd_i.tick_inc) begin
        tick_q <= tick_inc;
        fcnt_q <= '0;
        for (int k = 0; k < NUM_CFG_LV; k++) begin
          if ((tick_inc == '0) ||
              (({1'b0, phase_q[k]} + 1'b1) == {1'b0, per_q[k]})) begin
            phase_q[k] <= '0;
          end else begin
            phase_q[k] <= phase_q[k] + 1'b1;
          end
        end
      end
      // output register drains on acceptance
      if (res_valid_o && res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.add_write) begin
        valid_q[idx_i] <= 1'b1;
      end
      if (cmd_i.add_zero || cmd_i.add_write || cmd_i.add_full) begin
        pend_valid_q <= 1'b1;
      end
      if (cmd_i.walk_step && fire) begin
        valid_q[idx_i] <= 1'b0;
        fcnt_q         <= fcnt_q + 1'b1;
        pend_valid_q   <= 1'b1;
        if (pend_valid_q) begin
          out_valid_q <= 1'b1;
        end
      end
      if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
        out_valid_q  <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rtype_q <= req_type_i;
      delay_q <= delay_i;
      rpay_q  <= payload_i;
    end
    if (cmd_i.div_start) begin
      div_rem_q <= '0;
      div_lv_q  <= cfg_off[1:0];
    end else if (cmd_i.div_step) begin
      div_rem_q <= div_next[PER_W-1:0];
    end
    if (cmd_i.add_write) begin
      deadline_q[idx_i] <= tick_q + TICK_W'(delay_q);
      payload_q[idx_i]  <= rpay_q;
      level_q[idx_i]    <= pick_level(TICK_W'(delay_q), thr_q, NUM_LEVELS);
      pend_kind_q       <= RES_ADDED;
      pend_slot_q       <= idx_slot;
      pend_pay_q        <= '0;
    end
    if (cmd_i.add_zero || cmd_i.add_full) begin
      pend_kind_q <= cmd_i.add_zero ? RES_ZERO_DELAY : RES_NO_SLOT;
      pend_slot_q <= '0;
      pend_pay_q  <= '0;
    end
    if (cmd_i.walk_step && match) begin
      if (fire) begin
        if (pend_valid_q) begin
          out_kind_q <= pend_kind_q;
          out_slot_q <= pend_slot_q;
          out_pay_q  <= pend_pay_q;
          out_last_q <= 1'b0;
        end
        pend_kind_q <= RES_FIRED;
        pend_slot_q <= idx_slot;
        pend_pay_q  <= payload_q[idx_i];
      end else begin
        level_q[idx_i] <= pick_level(rem, thr_q, NUM_LEVELS);
      end
    end
    if (cmd_i.flush) begin
      out_kind_q <= pend_kind_q;
      out_slot_q <= pend_slot_q;
      out_pay_q  <= pend_pay_q;
      out_last_q <= 1'b1;
    end
  end

  assign res_valid_o   = out_valid_q;
  assign res_kind_o    = out_kind_q;
  assign res_slot_o    = out_slot_q;
  assign res_payload_o = out_pay_q;
  assign res_last_o    = out_last_q;

endmodule
